@@ rtl/nmcf_pkg.sv @@
// ----------------------------------------------------------------------------
// nmcf_pkg
// Shared types and constants of the normal map cavity filter.
// ----------------------------------------------------------------------------
package nmcf_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ColW      = $clog2(MaxWidth);   // 10
  localparam int unsigned RowW      = $clog2(MaxHeight);  // 12
  localparam int unsigned WCfgW     = 11;
  localparam int unsigned HCfgW     = 13;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned QuotW     = 9;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;

  typedef struct packed {
    logic       action;
    logic [7:0] normal_x;
    logic [7:0] normal_y;
  } in_t;

  typedef struct packed {
    logic [7:0]      cavity;
    logic            has_value;
    logic [ColW-1:0] column;
    logic [RowW-1:0] row;
    logic            end_of_image;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic rd;        // latch item, read line stores
    logic shift;     // write line stores, shift window, step counters
    logic sum1;      // gather neighbor terms
    logic sum2;      // diagonal product
    logic sum3;      // numerator, divider setup
    logic div_step;  // one quotient bit
    logic load_out;  // move result to output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;      // early flush: ignored
    logic emit;      // this item produces a result
    logic out_busy;  // output register still held
  } sts_t;

endpackage

@@ rtl/nmcf_ctrl.sv @@
// ----------------------------------------------------------------------------
// nmcf_ctrl
// Sequencer: steps one item through read and shift phases, then sum and divide phases when it emits a result.
// ----------------------------------------------------------------------------
module nmcf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  nmcf_pkg::sts_t sts_i,
  output nmcf_pkg::cmd_t cmd_o
);
  import nmcf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_SHIFT, ST_SUM1, ST_SUM2, ST_SUM3, ST_DIV, ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [3:0]         cnt_q, cnt_d;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i && !sts_i.skip) state_d = ST_READ;
      ST_READ:  state_d = ST_SHIFT;
      ST_SHIFT: state_d = sts_i.emit ? ST_SUM1 : ST_IDLE;
      ST_SUM1:  state_d = ST_SUM2;
      ST_SUM2:  state_d = ST_SUM3;
      ST_SUM3: begin
        state_d = ST_DIV;
        cnt_d   = 4'(QuotW - 1);
      end
      ST_DIV: begin
        if (cnt_q == 4'd0) state_d = ST_DONE;
        else cnt_d = cnt_q - 4'd1;
      end
      ST_DONE:  if (!sts_i.out_busy) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // commands
  assign in_ready_o      = (state_q == ST_IDLE);
  assign cmd_o.rd        = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.shift     = (state_q == ST_SHIFT);
  assign cmd_o.sum1      = (state_q == ST_SUM1);
  assign cmd_o.sum2      = (state_q == ST_SUM2);
  assign cmd_o.sum3      = (state_q == ST_SUM3);
  assign cmd_o.div_step  = (state_q == ST_DIV);
  assign cmd_o.load_out  = (state_q == ST_DONE) && !sts_i.out_busy;

endmodule

@@ rtl/nmcf_dp.sv @@
// ----------------------------------------------------------------------------
// nmcf_dp
// Datapath: line stores, 3x3 window, stream counters, weighted sum, divider.
// ----------------------------------------------------------------------------
module nmcf_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nmcf_pkg::in_t                 in_data_i,
  input  logic                          cfg_valid_i,
  input  logic [nmcf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nmcf_pkg::CfgDataW-1:0] cfg_data_i,
  input  nmcf_pkg::cmd_t                cmd_i,
  output nmcf_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output nmcf_pkg::out_t                out_data_o
);
  import nmcf_pkg::*;

  // config
  logic [WCfgW-1:0] wcfg_q;
  logic [HCfgW-1:0] hcfg_q;
  logic [WCfgW-1:0] w_eff;
  logic [HCfgW-1:0] h_eff;
  logic             cfg_hit;

  // stream state
  logic [ColW-1:0]  in_col_q, out_col_q;
  logic [RowW-1:0]  in_row_q, out_row_q;
  logic [WCfgW-1:0] fill_q;
  logic             done_q;
  logic [15:0]      texel_q;
  logic [15:0]      win_q [9];
  logic [15:0]      mem_a [MaxWidth];
  logic [15:0]      mem_b [MaxWidth];
  logic [15:0]      top_q, mid_q;
  logic             last_now, emit_now, col_end;

  // result pipeline
  logic             l_q, rt_q, up_q, dn_q, last_q;
  logic [ColW-1:0]  col_q;
  logic [RowW-1:0]  row_q;
  logic [9:0]       a_sum_q;
  logic signed [11:0] u_sum_q;
  logic [2:0]       na_q, nd_q;
  logic [10:0]      t_q;
  logic signed [21:0] p_q;
  logic             pos_q;
  logic [31:0]      rem_q, dsh_q;
  logic [QuotW-1:0] quo_q;
  logic             out_valid_q;
  out_t             out_q;

  // effective dimensions
  always_comb begin
    if (wcfg_q == '0) w_eff = WCfgW'(1);
    else if (wcfg_q > WCfgW'(MaxWidth)) w_eff = WCfgW'(MaxWidth);
    else w_eff = wcfg_q;
    if (hcfg_q == '0) h_eff = HCfgW'(1);
    else if (hcfg_q > HCfgW'(MaxHeight)) h_eff = HCfgW'(MaxHeight);
    else h_eff = hcfg_q;
  end

  assign cfg_hit  = cfg_valid_i && (cfg_index_i == RegWidth || cfg_index_i == RegHeight);
  assign emit_now = (fill_q >= w_eff + WCfgW'(1));
  assign last_now = ({1'b0, out_col_q} + WCfgW'(1) >= w_eff) &&
                    ({1'b0, out_row_q} + HCfgW'(1) >= h_eff);
  assign col_end  = ({1'b0, in_col_q} + WCfgW'(1) >= w_eff);

  assign sts_o.skip     = in_data_i.action && !done_q;
  assign sts_o.emit     = emit_now;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcfg_q <= WCfgW'(1024);
      hcfg_q <= HCfgW'(1024);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegWidth:  wcfg_q <= cfg_data_i[WCfgW-1:0];
        RegHeight: hcfg_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // line stores, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      top_q <= mem_b[in_col_q];
      mid_q <= mem_a[in_col_q];
    end
    if (cmd_i.shift) begin
      mem_b[in_col_q] <= mid_q;
      mem_a[in_col_q] <= texel_q;
    end
  end

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) texel_q <= done_q ? 16'h0 : {in_data_i.normal_y, in_data_i.normal_x};
  end

  // window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (cmd_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= top_q;
      win_q[5] <= mid_q;
      win_q[8] <= texel_q;
    end
  end

  // stream counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      fill_q    <= '0;
      done_q    <= 1'b0;
    end else if (cfg_hit) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      fill_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      if (cmd_i.rd && !done_q && !in_data_i.action && col_end) begin
        if ({1'b0, in_row_q} + HCfgW'(1) >= h_eff) begin
          done_q   <= 1'b1;
          in_row_q <= '0;
        end else begin
          in_row_q <= in_row_q + RowW'(1);
        end
      end
      if (cmd_i.shift) begin
        // image end also returns the input column to zero
        in_col_q <= (col_end || (emit_now && last_now)) ? '0 : in_col_q + ColW'(1);
        if (!emit_now) begin
          fill_q <= fill_q + WCfgW'(1);
        end else if (last_now) begin
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          fill_q    <= '0;
          done_q    <= 1'b0;
        end else if ({1'b0, out_col_q} + WCfgW'(1) >= w_eff) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + RowW'(1);
        end else begin
          out_col_q <= out_col_q + ColW'(1);
        end
      end
    end
  end

  // diagonal direction term, sx*(2x-255)+sy*(2y-255)
  function automatic logic signed [11:0] diag_u(logic [15:0] t, logic neg_x, logic neg_y);
    logic signed [10:0] nx, ny;
    nx = 11'(signed'({3'b0, t[7:0]}) * 2) - 11'sd255;
    ny = 11'(signed'({3'b0, t[15:8]}) * 2) - 11'sd255;
    return (neg_x ? -12'(nx) : 12'(nx)) + (neg_y ? -12'(ny) : 12'(ny));
  endfunction

  // capture position and edge flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift && emit_now) begin
      col_q  <= out_col_q;
      row_q  <= out_row_q;
      last_q <= last_now;
      l_q    <= (out_col_q != '0);
      rt_q   <= ({1'b0, out_col_q} + WCfgW'(1) < w_eff);
      up_q   <= (out_row_q != '0);
      dn_q   <= ({1'b0, out_row_q} + HCfgW'(1) < h_eff);
    end
  end

  // sum phases
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum1) begin
      a_sum_q <= (rt_q ? 10'(win_q[5][7:0]) : 10'd0)
               + (l_q  ? 10'(8'd255 - win_q[3][7:0]) : 10'd0)
               + (up_q ? 10'(win_q[1][15:8]) : 10'd0)
               + (dn_q ? 10'(8'd255 - win_q[7][15:8]) : 10'd0);
      u_sum_q <= ((rt_q && up_q) ? diag_u(win_q[2], 1'b0, 1'b0) : 12'sd0)
               + ((l_q  && up_q) ? diag_u(win_q[0], 1'b1, 1'b0) : 12'sd0)
               + ((l_q  && dn_q) ? diag_u(win_q[6], 1'b1, 1'b1) : 12'sd0)
               + ((rt_q && dn_q) ? diag_u(win_q[8], 1'b0, 1'b1) : 12'sd0);
      na_q <= 3'(rt_q) + 3'(l_q) + 3'(up_q) + 3'(dn_q);
      nd_q <= 3'(rt_q && up_q) + 3'(l_q && up_q) + 3'(l_q && dn_q) + 3'(rt_q && dn_q);
    end
    if (cmd_i.sum2) begin
      p_q <= 22'(signed'({1'b0, nd_q}) * 22'sd65280) + 22'(u_sum_q * 22'sd181);
      t_q <= 11'(na_q) * 11'd256 + 11'(nd_q) * 11'd181;
    end
  end

  // numerator and divider
  logic signed [31:0] s_val, num_val;
  logic               ge;
  assign s_val   = 32'(signed'({1'b0, a_sum_q}) * 32'sd131072) + 32'(p_q * 32'sd181);
  assign num_val = 32'(s_val * 2) + 32'(signed'({1'b0, t_q}) * 32'sd512);
  assign ge      = (rem_q >= dsh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum3) begin
      pos_q <= (num_val > 32'sd0) && (t_q != '0);
      rem_q <= num_val;
      dsh_q <= {3'b0, t_q, 18'b0};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[QuotW-2:0], ge};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.load_out) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.cavity       <= !pos_q ? 8'd0 : (quo_q[QuotW-1] ? 8'd255 : quo_q[7:0]);
      out_q.has_value    <= (t_q != '0);
      out_q.column       <= col_q;
      out_q.row          <= row_q;
      out_q.end_of_image <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/normal_map_cavity_filter.sv @@
// ----------------------------------------------------------------------------
// normal_map_cavity_filter
// Cavity filter over a normal map streamed in raster order.
// ----------------------------------------------------------------------------
// Input channel: one texel (normal x/y bytes) or flush item per transfer.
// Output channel: cavity byte, has_value, column, row, end_of_image.
// Config channel: index 0 = image width, index 1 = image height; a write to
//   either restarts the stream counters and is taken in any cycle.
// Each item goes through a line-store read and a shift phase. Results appear
//   one row and one texel behind the input; an item that produces one then
//   goes through the sum1, sum2 and sum3 phases, a restoring divider (one
//   quotient bit a cycle) and a load of the output register.
// After the last texel, flush items drain the last row.
// The output register decouples the sides: a new item is taken while a
//   result waits; if the receiver stalls, the next result waits in the
//   sequencer and input is held off.
// Reset clears counters and window, width and height return to 1024;
//   line stores are not cleared.
// ----------------------------------------------------------------------------
module normal_map_cavity_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  nmcf_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output nmcf_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nmcf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nmcf_pkg::CfgDataW-1:0] cfg_data_i
);
  import nmcf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  nmcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nmcf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/nmcf_checker.sv @@
// ----------------------------------------------------------------------------
// nmcf_checker
// Port-level checks of the cavity filter, bound to the top level.
// ----------------------------------------------------------------------------
module nmcf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input nmcf_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input nmcf_pkg::out_t out_data_o
);

  // a held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // a texel transfer keeps the block busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.action |=> !in_ready_o)
    else $error("input taken while busy");

  // no neighbor means zero cavity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_value |-> out_data_o.cavity == 8'd0)
    else $error("cavity without neighbors");

  // a result only follows a texel or flush transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o || $past(!in_ready_o))
    else $error("result without work");

endmodule

bind normal_map_cavity_filter nmcf_checker u_nmcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ bench/normal_map_cavity_filter_test.sv @@
// ----------------------------------------------------------------------------
// normal_map_cavity_filter_test
// Self-checking bench: streams normal-map images through the cavity filter
// under several idle/stall mixes, predicts each cavity texel in the bench
// and compares every output transfer field by field, in order.
// ----------------------------------------------------------------------------
module normal_map_cavity_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nmcf_pkg::*;

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StallLimit  = 20000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  normal_map_cavity_filter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bench-side filter state
  logic [15:0] line_a [MaxWidth];
  logic [15:0] line_b [MaxWidth];
  logic [15:0] win [9];
  int unsigned img_w, img_h;
  int unsigned col_in, row_in, out_idx, fill_cnt;
  bit          input_done;

  out_t        cavity_q[$];
  int          fails = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_hold = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic restart_stream();
    col_in = 0;
    row_in = 0;
    out_idx = 0;
    fill_cnt = 0;
    input_done = 1'b0;
  endtask

  function automatic longint diag_term(logic [15:0] t, int sx, int sy);
    longint nx, ny, u;
    nx = 2 * longint'(t[7:0]) - 255;
    ny = 2 * longint'(t[15:8]) - 255;
    u = sx * nx + sy * ny;
    return 181 * (65280 + 181 * u);
  endfunction

  task automatic shift_column(logic [15:0] texel);
    int unsigned k;
    logic [15:0] top, mid;
    k = (col_in < img_w) ? col_in : 0;
    top = line_b[k];
    mid = line_a[k];
    line_b[k] = mid;
    line_a[k] = texel;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = texel;
    col_in = (k + 1 >= img_w) ? 0 : k + 1;
  endtask

  // advance the filter model by one accepted item, queue any cavity texel
  task automatic predict_cavity(in_t it);
    int unsigned c, r;
    bit lf, rt, up, dn, last;
    longint s, t, num, q;
    out_t res;
    if (!input_done) begin
      if (it.action) return;  // early flush is ignored
      if (col_in + 1 >= img_w) begin
        if (row_in + 1 >= img_h) begin
          input_done = 1'b1;
          row_in = 0;
        end else begin
          row_in++;
        end
      end
      shift_column({it.normal_y, it.normal_x});
    end else begin
      shift_column(16'h0000);
    end
    if (fill_cnt < img_w + 1) begin
      fill_cnt++;
      return;
    end
    c = out_idx % img_w;
    r = out_idx / img_w;
    lf = c >= 1;
    rt = c + 1 < img_w;
    up = r >= 1;
    dn = r + 1 < img_h;
    last = out_idx + 1 >= img_w * img_h;
    s = 0;
    t = 0;
    if (rt) begin s += 131072 * longint'(win[5][7:0]); t += 256; end
    if (lf) begin s += 131072 * (255 - longint'(win[3][7:0])); t += 256; end
    if (up) begin s += 131072 * longint'(win[1][15:8]); t += 256; end
    if (dn) begin s += 131072 * (255 - longint'(win[7][15:8])); t += 256; end
    if (rt && up) begin s += diag_term(win[2], 1, 1); t += 181; end
    if (lf && up) begin s += diag_term(win[0], -1, 1); t += 181; end
    if (lf && dn) begin s += diag_term(win[6], -1, -1); t += 181; end
    if (rt && dn) begin s += diag_term(win[8], 1, -1); t += 181; end
    res = '0;
    if (t > 0) begin
      num = 2 * s + 512 * t;
      if (num > 0) begin
        q = num / (1024 * t);
        res.cavity = (q > 255) ? 8'd255 : q[7:0];
      end
    end
    res.has_value = t > 0;
    res.column = c[ColW-1:0];
    res.row = r[RowW-1:0];
    res.end_of_image = last;
    cavity_q.push_back(res);
    if (last) restart_stream();
    else out_idx++;
  endtask

  // one input transfer, with random idle gaps before it
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_cavity(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cavity_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == RegWidth) img_w = clamp(val & 13'h7FF, MaxWidth);
    else img_h = clamp(val, MaxHeight);
    restart_stream();
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic in_t rand_texel(bit act);
    in_t it;
    it.action = act;
    it.normal_x = pick_byte();
    it.normal_y = pick_byte();
    return it;
  endfunction

  // one whole image plus the drain items; noise_pct adds ignored flushes
  task automatic run_image(int unsigned noise_pct);
    for (int unsigned i = 0; i < img_w * img_h; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(rand_texel(1'b1));
      send_item(rand_texel(1'b0));
    end
    // drain: a texel after the image end acts as a flush
    for (int unsigned i = 0; i <= img_w; i++) send_item(rand_texel($urandom_range(3) != 0));
  endtask

  // first part of an image; the next register write restarts the stream
  task automatic send_texels(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(rand_texel(1'b0));
  endtask

  task automatic test_directed();
    in_t it;
    write_reg(RegWidth, 13'd3);
    write_reg(RegHeight, 13'd3);
    for (int i = 0; i < 9; i++) begin
      it.action = 1'b0;
      it.normal_x = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : 8'h80;
      it.normal_y = (i % 2 == 0) ? 8'hFF : 8'h00;
      send_item(it);
      if (i == 4) send_item('{action: 1'b1, normal_x: 8'hAA, normal_y: 8'h55});
    end
    for (int i = 0; i < 4; i++) send_item('{action: 1'b1, normal_x: 8'h00, normal_y: 8'h00});
    // flush after the image end: ignored
    send_item('{action: 1'b1, normal_x: 8'hFF, normal_y: 8'hFF});
    // single texel: no neighbor at all
    write_reg(RegWidth, 13'd1);
    write_reg(RegHeight, 13'd1);
    send_item('{action: 1'b0, normal_x: 8'hFF, normal_y: 8'h00});
    send_item('{action: 1'b0, normal_x: 8'h12, normal_y: 8'h34});
    send_item('{action: 1'b1, normal_x: 8'h00, normal_y: 8'hFF});
  endtask

  task automatic test_size_extremes();
    write_reg(RegWidth, 13'd0);      // clamps to 1
    write_reg(RegHeight, 13'h1FFF);  // clamps to max height
    send_texels(200);
    write_reg(RegWidth, 13'h1FFF);   // masked, clamps to max width
    write_reg(RegHeight, 13'd0);     // clamps to 1
    send_texels(100);
  endtask

  task automatic test_random_phase(int unsigned gap, int unsigned stall, int unsigned n);
    int unsigned sent;
    wait_drained();
    send_gap_pct = gap;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < n) begin
      write_reg(RegWidth, CfgDataW'($urandom_range(1, 8)));
      write_reg(RegHeight, CfgDataW'($urandom_range(1, 6)));
      run_image(10);
      sent += img_w * img_h + img_w + 1;
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_reg(RegWidth, 13'd5);
    write_reg(RegHeight, 13'd4);
    recv_hold = 600;
    run_image(0);
    wait_drained();  // sender waits for every result
    run_image(0);
  endtask

  // output side: ready pattern and checking
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (cavity_q.size() == 0) begin
        $display("%t: unexpected output transfer %p", $realtime, out_data);
        fails++;
      end else begin
        out_t e;
        e = cavity_q.pop_front();
        if (out_data.cavity !== e.cavity) begin
          $display("%t: cavity exp %0d got %0d", $realtime, e.cavity, out_data.cavity);
          fails++;
        end
        if (out_data.has_value !== e.has_value) begin
          $display("%t: has_value exp %0d got %0d", $realtime, e.has_value,
                   out_data.has_value);
          fails++;
        end
        if (out_data.column !== e.column) begin
          $display("%t: column exp %0d got %0d", $realtime, e.column, out_data.column);
          fails++;
        end
        if (out_data.row !== e.row) begin
          $display("%t: row exp %0d got %0d", $realtime, e.row, out_data.row);
          fails++;
        end
        if (out_data.end_of_image !== e.end_of_image) begin
          $display("%t: end_of_image exp %0d got %0d", $realtime, e.end_of_image,
                   out_data.end_of_image);
          fails++;
        end
      end
    end
    if (recv_hold > 0) begin
      recv_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MaxWidth; i++) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    img_w = 1024;
    img_h = 1024;
    restart_stream();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_size_extremes();
    test_random_phase(0, 0, 150);
    test_random_phase(81, 0, 150);
    test_random_phase(0, 81, 150);
    test_random_phase(17, 17, 150);
    test_backpressure();
    wait_drained();

    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/nmcf_pkg.sv
rtl/nmcf_ctrl.sv
rtl/nmcf_dp.sv
rtl/normal_map_cavity_filter.sv
rtl/nmcf_checker.sv
bench/normal_map_cavity_filter_test.sv
